>>> rtl/lrg_pkg.sv
// Package for the Lehmer random generator: item type, operation codes and
// generator constants. No dependencies.

package lrg_pkg;

   // operation codes on the request channel
   localparam logic LRG_OP_SEED = 1'b0;
   localparam logic LRG_OP_DRAW = 1'b1;

   // generator modulus 2^31 - 1 and multiplier
   localparam logic [30:0] LRG_MODULUS    = 31'h7FFF_FFFF;
   localparam logic [14:0] LRG_MULTIPLIER = 15'd16807;

   // seed reduction modulus 2^31 - 2 and twice that
   localparam logic [31:0] LRG_SEED_MOD   = 32'h7FFF_FFFE;
   localparam logic [31:0] LRG_SEED_MOD2  = 32'hFFFF_FFFC;

   // reset value of the generator
   localparam logic [30:0] LRG_RESET_VALUE = 31'd1;

   // hand-off queue between front and back
   localparam int LRG_QUEUE_DEPTH = 2;
   localparam int LRG_PTR_W       = (LRG_QUEUE_DEPTH > 1) ? $clog2(LRG_QUEUE_DEPTH) : 1;
   localparam int LRG_CNT_W       = $clog2(LRG_QUEUE_DEPTH + 1);

   // remainder unit: one quotient bit per cycle over the 31-bit value
   localparam int LRG_DIV_STEPS = 31;
   localparam int LRG_STEP_W    = $clog2(LRG_DIV_STEPS);

   typedef struct packed {
      logic        draw;
      logic [30:0] raw_value;
      logic [30:0] range_limit;
   } lrg_item_type;

endpackage

>>> rtl/lrg_front.sv
// Front part: holds the generator value, seeds or advances it per beat.
// Depends on lrg_pkg.

module lrg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 operation,
   input  logic [31:0]          seed_value,
   input  logic [30:0]          range_limit,
   output lrg_pkg::lrg_item_type item
);
   import lrg_pkg::*;

   logic [30:0] gen_ff;
   logic [30:0] gen_in;
   logic [45:0] product;
   logic [31:0] folded;
   logic [30:0] advanced;
   logic [31:0] seed_red;
   logic [30:0] seeded;

   // 2^31 = 1 mod (2^31 - 1): fold the high part onto the low part
   assign product  = 46'(gen_ff) * 46'(LRG_MULTIPLIER);
   assign folded   = {1'b0, product[30:0]} + {17'b0, product[45:31]};
   assign advanced = (folded >= {1'b0, LRG_MODULUS}) ?
                     31'(folded - {1'b0, LRG_MODULUS}) : folded[30:0];

   always_comb begin
      if (seed_value >= LRG_SEED_MOD2) begin
         seed_red = seed_value - LRG_SEED_MOD2;
      end else if (seed_value >= LRG_SEED_MOD) begin
         seed_red = seed_value - LRG_SEED_MOD;
      end else begin
         seed_red = seed_value;
      end
   end
   assign seeded = 31'(seed_red) + 31'd1;

   always_comb begin
      gen_in = gen_ff;
      if (push) begin
         gen_in = (operation == LRG_OP_DRAW) ? advanced : seeded;
      end
   end

   assign item.draw        = (operation == LRG_OP_DRAW);
   assign item.raw_value   = gen_in;
   assign item.range_limit = range_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= LRG_RESET_VALUE;
      end else begin
         gen_ff <= gen_in;
      end
   end

   gen_in_range: assert property (@(posedge clock) disable iff (reset)
      gen_ff != 31'd0 && gen_ff != LRG_MODULUS)
      else $error("generator value left its legal range");

endmodule

>>> rtl/lrg_queue.sv
// Short hand-off queue of classified items between front and back.
// Depends on lrg_pkg.

module lrg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lrg_pkg::lrg_item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output lrg_pkg::lrg_item_type pop_item,
   output logic                 empty
);
   import lrg_pkg::*;

   lrg_item_type         slot_ff [LRG_QUEUE_DEPTH];
   logic [LRG_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LRG_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LRG_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == LRG_CNT_W'(LRG_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LRG_PTR_W'(LRG_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LRG_PTR_W'(LRG_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LRG_CNT_W'(LRG_QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

>>> rtl/lrg_back.sv
// Back part: bit-serial remainder unit and result register.
// Depends on lrg_pkg.

module lrg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lrg_pkg::lrg_item_type q_item,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [30:0]          rsp_raw_value,
   output logic [30:0]          rsp_bounded_value
);
   import lrg_pkg::*;

   typedef enum logic [1:0] {IDLE, RUN, DONE} state_type;

   state_type             state_ff, state_in;
   logic [30:0]           raw_ff, raw_in;
   logic [30:0]           lim_ff, lim_in;
   logic [30:0]           rem_ff, rem_in;
   logic [30:0]           dvd_ff, dvd_in;
   logic [LRG_STEP_W-1:0] step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;
   logic [30:0]           out_raw_ff, out_raw_in;
   logic [30:0]           out_bnd_ff, out_bnd_in;
   logic                  out_free;
   logic                  trivial;
   logic [31:0]           shifted;

   assign out_free = !out_valid_ff || rsp_pop;
   assign trivial  = !q_item.draw || (q_item.range_limit == '0);
   assign shifted  = {rem_ff, dvd_ff[30]};

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      lim_in       = lim_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_raw_in   = out_raw_ff;
      out_bnd_in   = out_bnd_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (!q_empty) begin
               if (trivial) begin
                  // no reduction needed: straight into the result register
                  if (out_free) begin
                     q_pop        = 1'b1;
                     out_valid_in = 1'b1;
                     out_raw_in   = q_item.raw_value;
                     out_bnd_in   = '0;
                  end
               end else begin
                  q_pop    = 1'b1;
                  raw_in   = q_item.raw_value;
                  dvd_in   = q_item.raw_value;
                  lim_in   = q_item.range_limit;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = RUN;
               end
            end
         end
         RUN: begin
            // one restoring step: shift in the next dividend bit, subtract if it fits
            if (shifted >= {1'b0, lim_ff}) begin
               rem_in = 31'(shifted - {1'b0, lim_ff});
            end else begin
               rem_in = shifted[30:0];
            end
            dvd_in  = {dvd_ff[29:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == LRG_STEP_W'(LRG_DIV_STEPS - 1)) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_raw_in   = raw_ff;
               out_bnd_in   = rem_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      raw_ff     <= raw_in;
      lim_ff     <= lim_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      step_ff    <= step_in;
      out_raw_ff <= out_raw_in;
      out_bnd_ff <= out_bnd_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_raw_value     = out_raw_ff;
   assign rsp_bounded_value = out_bnd_ff;

   rem_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == DONE |-> rem_ff < lim_ff)
      else $error("remainder not below range limit");

   step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> step_ff <= LRG_STEP_W'(LRG_DIV_STEPS - 1))
      else $error("remainder step count overran");

   pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule

>>> rtl/lehmer_random_generator.sv
// Top level of the Lehmer (minimal standard) random generator.
// Depends on lrg_pkg, lrg_front, lrg_queue and lrg_back.
//
// Usage:
//   Request channel (req_): a beat is taken when req_push is high and
//   req_full low. req_operation selects load seed or draw. A seed load sets
//   the generator to (req_seed_value mod (2^31 - 2)) + 1; a draw advances it
//   by z' = 16807 * z mod (2^31 - 1), worked out in the front in the cycle
//   the beat is taken, so back-to-back requests are always in order.
//   Result channel (rsp_): while rsp_empty is low the oldest result sits on
//   rsp_raw_value and rsp_bounded_value; rsp_pop takes it.
//   A seed load, or a draw with a zero range limit, goes through the queue
//   straight into the result register. A draw with a non-zero range limit
//   runs through the bit-serial remainder unit in 31 steps; the unit takes
//   no new bounded draw until the last is handed on. Seed loads and
//   unbounded draws go at one per cycle while the unit is idle and results are taken.
//   A two-beat queue between front and back lets requests be taken while
//   the remainder unit is busy; req_full rises once it fills.
//   If the receiver stalls, the result register holds its beat and the back
//   part waits; the queue then fills and back-pressure reaches req_full.
//   Reset (synchronous) sets the generator to 1 and empties queue and
//   result register.

module lehmer_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [31:0] req_seed_value,
   input  logic [30:0] req_range_limit,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [30:0] rsp_raw_value,
   output logic [30:0] rsp_bounded_value
);
   import lrg_pkg::*;

   lrg_item_type front_item;
   lrg_item_type back_item;
   logic         accept;
   logic         q_empty;
   logic         q_pop;

   // advance the generator only on a taken beat
   assign accept = req_push && !req_full;

   lrg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .operation   (req_operation),
      .seed_value  (req_seed_value),
      .range_limit (req_range_limit),
      .item        (front_item)
   );

   lrg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   lrg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_item            (back_item),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_bounded_value (rsp_bounded_value)
   );

endmodule

>>> tb/sv/lrg_checker.sv
// Checker for the Lehmer random generator: watches both channels, predicts
// each result from its own copy of the generator value and compares them.
// Depends on lrg_pkg.

module lrg_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_operation,
   input  logic [31:0] req_seed_value,
   input  logic [30:0] req_range_limit,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [30:0] rsp_raw_value,
   input  logic [30:0] rsp_bounded_value,
   output int          mismatch_count,
   output int          outcomes_waiting,
   output int          seed_loads,
   output int          reduced_draws,
   output int          zero_limit_draws
);
   import lrg_pkg::*;

   typedef struct packed {
      logic [30:0] raw_value;
      logic [30:0] bounded_value;
   } lrg_outcome_type;

   lrg_outcome_type outcome_queue[$];
   logic [30:0]     model_value;

   // z' = 16807 * z mod (2^31 - 1), folded twice since 2^31 = 1 mod the modulus
   function automatic logic [30:0] lehmer_advance(input logic [30:0] z);
      logic [63:0] product;
      logic [63:0] folded;
      product = 64'(z) * 64'(LRG_MULTIPLIER);
      folded  = (product & 64'h7FFF_FFFF) + (product >> 31);
      folded  = (folded & 64'h7FFF_FFFF) + (folded >> 31);
      if (folded >= 64'(LRG_MODULUS))
         folded = folded - 64'(LRG_MODULUS);
      return folded[30:0];
   endfunction

   function automatic logic [30:0] seeded_value(input logic [31:0] seed);
      logic [63:0] wide;
      wide = (64'(seed) % 64'(LRG_SEED_MOD)) + 64'd1;
      return wide[30:0];
   endfunction

   always @(posedge clock) begin
      lrg_outcome_type predicted;
      lrg_outcome_type oldest;
      if (reset) begin
         model_value      = LRG_RESET_VALUE;
         outcome_queue.delete();
         mismatch_count   = 0;
         seed_loads       = 0;
         reduced_draws    = 0;
         zero_limit_draws = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (outcome_queue.size() == 0) begin
               $error("unexpected result: raw_value %0d bounded_value %0d",
                      rsp_raw_value, rsp_bounded_value);
               mismatch_count++;
            end else begin
               oldest = outcome_queue.pop_front();
               if (rsp_raw_value !== oldest.raw_value) begin
                  $error("raw_value: expected %0d, got %0d",
                         oldest.raw_value, rsp_raw_value);
                  mismatch_count++;
               end
               if (rsp_bounded_value !== oldest.bounded_value) begin
                  $error("bounded_value: expected %0d, got %0d",
                         oldest.bounded_value, rsp_bounded_value);
                  mismatch_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            predicted.bounded_value = '0;
            if (req_operation == LRG_OP_SEED) begin
               model_value = seeded_value(req_seed_value);
               seed_loads++;
            end else begin
               model_value = lehmer_advance(model_value);
               if (req_range_limit != '0) begin
                  predicted.bounded_value = model_value % req_range_limit;
                  reduced_draws++;
               end else begin
                  zero_limit_draws++;
               end
            end
            predicted.raw_value = model_value;
            outcome_queue.push_back(predicted);
         end
      end
      outcomes_waiting = outcome_queue.size();
   end

endmodule

>>> tb/sv/lehmer_random_generator_tb.sv
// Testbench top for the Lehmer random generator: clock, reset, stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on lrg_pkg, lrg_checker and the lehmer_random_generator RTL.

module lehmer_random_generator_tb;
   import lrg_pkg::*;

   localparam int RANDOM_BEATS  = 1150;
   localparam int CALM_FIRST    = 450;   // no idling on either side from here ...
   localparam int CALM_LAST     = 700;   // ... up to here
   localparam int STALL_LIMIT   = 4000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES  = 60;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_operation;
   logic [31:0] req_seed_value;
   logic [30:0] req_range_limit;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [30:0] rsp_raw_value;
   logic [30:0] rsp_bounded_value;

   int mismatch_count;
   int outcomes_waiting;
   int seed_loads;
   int reduced_draws;
   int zero_limit_draws;
   int stall_cycles;
   bit calm;

   lehmer_random_generator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_operation     (req_operation),
      .req_seed_value    (req_seed_value),
      .req_range_limit   (req_range_limit),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_bounded_value (rsp_bounded_value)
   );

   lrg_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_operation     (req_operation),
      .req_seed_value    (req_seed_value),
      .req_range_limit   (req_range_limit),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_bounded_value (rsp_bounded_value),
      .mismatch_count    (mismatch_count),
      .outcomes_waiting  (outcomes_waiting),
      .seed_loads        (seed_loads),
      .reduced_draws     (reduced_draws),
      .zero_limit_draws  (zero_limit_draws)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: take results at random, but never stall inside the calm stretch.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   initial begin
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, outcomes_waiting);
            $display("lehmer_random_generator_tb NOT OK");
            $finish;
         end
      end
   end

   // Offer one request beat and hold it until taken. Entered and left at a
   // falling edge; idle gaps drop push first, unless in the calm stretch.
   task automatic offer_request(input logic op, input logic [31:0] seed,
                                input logic [30:0] limit);
      if (!calm) begin
         while ($urandom_range(0, 99) < 25) begin
            req_push <= 1'b0;
            @(negedge clock);
         end
      end
      req_push        <= 1'b1;
      req_operation   <= op;
      req_seed_value  <= seed;
      req_range_limit <= limit;
      do
         @(posedge clock);
      while (req_full);
      @(negedge clock);
   endtask

   // Seeds: mostly anything, otherwise hug multiples of the seed modulus.
   function automatic logic [31:0] pick_seed();
      logic [31:0] base;
      if ($urandom_range(0, 99) < 70)
         return $urandom();
      base = LRG_SEED_MOD * $urandom_range(0, 2);
      return base + 32'($urandom_range(0, 6)) - 32'd3;
   endfunction

   // Limits: zero, small, full width, or near the top of the range.
   function automatic logic [30:0] pick_limit();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 25)
         return '0;
      else if (kind < 55)
         return 31'($urandom_range(1, 100));
      else if (kind < 90)
         return 31'($urandom());
      else
         return LRG_MODULUS - 31'($urandom_range(0, 3));
   endfunction

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_operation   = LRG_OP_SEED;
      req_seed_value  = '0;
      req_range_limit = '0;
      calm            = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset value, seed wrap-around, extremes of both fields,
      // zero range limit on a draw, and the largest generator value.
      offer_request(LRG_OP_DRAW, 32'd0,          31'h7FFF_FFFF);
      offer_request(LRG_OP_DRAW, 32'd0,          31'd1);
      offer_request(LRG_OP_DRAW, 32'hFFFF_FFFF,  31'd0);
      offer_request(LRG_OP_SEED, 32'd0,          31'd0);
      offer_request(LRG_OP_SEED, 32'h7FFF_FFFD,  31'd5);
      offer_request(LRG_OP_DRAW, 32'd0,          31'h7FFF_FFFF);
      offer_request(LRG_OP_SEED, 32'h7FFF_FFFD,  31'd0);
      offer_request(LRG_OP_DRAW, 32'd0,          31'h7FFF_FFFE);
      offer_request(LRG_OP_SEED, 32'h7FFF_FFFE,  31'h7FFF_FFFF);
      offer_request(LRG_OP_SEED, 32'h7FFF_FFFF,  31'd0);
      offer_request(LRG_OP_SEED, 32'hFFFF_FFFF,  31'd0);
      offer_request(LRG_OP_SEED, 32'hFFFF_FFFC,  31'd0);
      offer_request(LRG_OP_SEED, 32'hFFFF_FFFB,  31'd0);
      offer_request(LRG_OP_DRAW, 32'd0,          31'd2);
      offer_request(LRG_OP_SEED, 32'h8000_0000,  31'd0);
      offer_request(LRG_OP_DRAW, 32'd0,          31'h4000_0000);
      offer_request(LRG_OP_DRAW, 32'd0,          31'd3);
      offer_request(LRG_OP_DRAW, 32'd0,          31'd0);
      offer_request(LRG_OP_DRAW, 32'hFFFF_FFFF,  31'h5555_5555);

      // Random: mostly draws with varied limits, a sprinkling of seed loads.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
         if ($urandom_range(0, 99) < 12)
            offer_request(LRG_OP_SEED, pick_seed(), 31'($urandom()));
         else
            offer_request(LRG_OP_DRAW, $urandom(), pick_limit());
      end
      calm = 1'b0;
      req_push <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (outcomes_waiting != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d seed loads, %0d reduced draws, %0d zero-limit draws",
               seed_loads, reduced_draws, zero_limit_draws);
      $display("with random idling on both sides and one stretch at full rate");
      if (mismatch_count == 0) begin
         $display("lehmer_random_generator_tb OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("lehmer_random_generator_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/lrg_pkg.sv
rtl/lrg_front.sv
rtl/lrg_queue.sv
rtl/lrg_back.sv
rtl/lehmer_random_generator.sv
tb/sv/lrg_checker.sv
tb/sv/lehmer_random_generator_tb.sv
